### rtl/sccb_pkg.sv
// Shared types and constants for the SCCB master bit engine.
// Used by the front end, the item queue and the back-end engine.
`timescale 1ns / 1ps

package sccb_pkg;

  typedef enum logic [2:0] {
    CMD_IDLE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4,
    CMD_NOACK = 3'd5
  } cmd_t;

  typedef enum logic {
    KIND_TICK = 1'b0,
    KIND_CMD  = 1'b1
  } kind_t;

  // Classified request as it travels from the front end to the engine.
  typedef struct packed {
    kind_t      kind;
    cmd_t       cmd;
    logic [7:0] wdata;
    logic       sda;
  } item_t;

  // Pin levels driven by the engine.
  typedef struct packed {
    logic scl;
    logic sda;
    logic en;
  } pins_t;

  localparam logic CFG_PHASE_TICKS = 1'b0;
  localparam logic CFG_ACK_WAIT    = 1'b1;

  localparam logic [15:0] PHASE_TICKS_RESET = 16'd100;
  localparam logic [15:0] ACK_WAIT_RESET    = 16'd1000;

  // Write phase whose length is the acknowledge hold.
  localparam logic [4:0] WRITE_ACK_PHASE = 5'd26;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

endpackage

### rtl/sccb_front.sv
// Front end: takes requests from the input stream and classifies them.
// Depends on sccb_pkg; feeds sccb_queue.
`timescale 1ns / 1ps

module sccb_front (
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [sccb_pkg::IN_DATA_W-1:0] s_tdata,  // wdata[7:0], sda_in[8], zero pad
  input  logic [2:0]                    s_tuser,  // op[2:0]
  input  logic                          q_full,
  output logic                          push,
  output sccb_pkg::item_t               item
);

  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;

  always_comb begin
    item.wdata = s_tdata[7:0];
    item.sda   = s_tdata[8];
    case (s_tuser)
      sccb_pkg::CMD_START,
      sccb_pkg::CMD_STOP,
      sccb_pkg::CMD_WRITE,
      sccb_pkg::CMD_READ,
      sccb_pkg::CMD_NOACK: begin
        item.kind = sccb_pkg::KIND_CMD;
        item.cmd  = sccb_pkg::cmd_t'(s_tuser);
      end
      default: begin
        // Plain ticks and the unused codes all advance time.
        item.kind = sccb_pkg::KIND_TICK;
        item.cmd  = sccb_pkg::CMD_IDLE;
      end
    endcase
  end

endmodule

### rtl/sccb_queue.sv
// Two-entry queue between the front end and the engine.
// Depends on sccb_pkg for the item type.
`timescale 1ns / 1ps

module sccb_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  sccb_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output sccb_pkg::item_t head
);

  sccb_pkg::item_t slots [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/sccb_engine.sv
// Back end: phase sequencer, tick counter, shifter and result register.
// Depends on sccb_pkg; takes items from sccb_queue.
`timescale 1ns / 1ps

module sccb_engine #(
  parameter int TICK_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [15:0]                    cfg_data,
  input  logic                           q_not_empty,
  input  sccb_pkg::item_t                q_head,
  output logic                           pop,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [sccb_pkg::OUT_DATA_W-1:0] m_tdata
);

  logic [15:0]           phase_ticks;
  logic [15:0]           ack_wait_ticks;
  sccb_pkg::cmd_t        cmd, cmd_next;
  logic [4:0]            phase, phase_next;
  logic [1:0]            sub, sub_next;
  logic [TICK_WIDTH-1:0] tick, tick_next;
  logic [7:0]            shift, shift_next;
  logic                  ack, ack_next;
  logic [7:0]            rdata, rdata_next;
  sccb_pkg::pins_t       pins, pins_next;
  logic                  done, rej;

  logic [31:0]           dur_ext;
  logic [TICK_WIDTH-1:0] dur_raw;
  logic [TICK_WIDTH-1:0] dur;
  logic [TICK_WIDTH-1:0] tick_inc;
  logic [4:0]            phase_inc;
  logic [4:0]            total;

  function automatic sccb_pkg::pins_t phase_begin(input sccb_pkg::cmd_t c,
                                                  input logic [4:0] p,
                                                  input logic [1:0] s,
                                                  input logic msb,
                                                  input sccb_pkg::pins_t cur);
    sccb_pkg::pins_t r;
    r = cur;
    case (c)
      sccb_pkg::CMD_START: begin
        if (p == 5'd0) begin
          r.en  = 1'b1;
          r.sda = 1'b1;
        end else if (p == 5'd1) r.scl = 1'b1;
        else if (p == 5'd2) r.sda = 1'b0;
        else r.scl = 1'b0;
      end
      sccb_pkg::CMD_STOP: begin
        if (p == 5'd0) begin
          r.en  = 1'b1;
          r.sda = 1'b0;
        end else if (p == 5'd1) r.scl = 1'b1;
        else r.sda = 1'b1;
      end
      sccb_pkg::CMD_NOACK: begin
        if (p == 5'd0) begin
          r.en  = 1'b1;
          r.sda = 1'b1;
        end else if (p == 5'd1) r.scl = 1'b1;
        else if (p == 5'd2) r.scl = 1'b0;
        else r.sda = 1'b0;
      end
      sccb_pkg::CMD_WRITE: begin
        if (p < 5'd24) begin
          if (s == 2'd0) begin
            r.en  = 1'b1;
            r.sda = msb;
          end else if (s == 2'd1) r.scl = 1'b1;
          else r.scl = 1'b0;
        end else if (p == 5'd25) r.en = 1'b0;
        else if (p == 5'd26) r.scl = 1'b1;
        else if (p == 5'd27) r.scl = 1'b0;
      end
      sccb_pkg::CMD_READ: begin
        if (p == 5'd0) r.en = 1'b0;
        else if (s == 2'd1) r.scl = 1'b1;
        else if (s == 2'd2) r.scl = 1'b0;
      end
      default: r = cur;
    endcase
    return r;
  endfunction

  // A new request enters whenever the result register is free or being taken.
  assign pop = q_not_empty && (!m_tvalid || m_tready);

  assign dur_ext  = {16'd0,
                     ((cmd == sccb_pkg::CMD_WRITE) && (phase == sccb_pkg::WRITE_ACK_PHASE))
                     ? ack_wait_ticks : phase_ticks};
  assign dur_raw  = dur_ext[TICK_WIDTH-1:0];
  assign dur      = (dur_raw == '0) ? {{(TICK_WIDTH-1){1'b0}}, 1'b1} : dur_raw;
  assign tick_inc = tick + {{(TICK_WIDTH-1){1'b0}}, 1'b1};
  assign phase_inc = phase + 5'd1;

  always_comb begin
    case (cmd)
      sccb_pkg::CMD_START: total = 5'd4;
      sccb_pkg::CMD_STOP:  total = 5'd3;
      sccb_pkg::CMD_WRITE: total = 5'd28;
      sccb_pkg::CMD_READ:  total = 5'd25;
      sccb_pkg::CMD_NOACK: total = 5'd4;
      default:             total = 5'd0;
    endcase
  end

  always_comb begin
    cmd_next   = cmd;
    phase_next = phase;
    sub_next   = sub;
    tick_next  = tick;
    shift_next = shift;
    ack_next   = ack;
    rdata_next = rdata;
    pins_next  = pins;
    done       = 1'b0;
    rej        = 1'b0;
    if (q_head.kind == sccb_pkg::KIND_CMD) begin
      if (cmd != sccb_pkg::CMD_IDLE) begin
        rej = 1'b1;
      end else begin
        cmd_next   = q_head.cmd;
        phase_next = 5'd0;
        tick_next  = '0;
        shift_next = (q_head.cmd == sccb_pkg::CMD_WRITE) ? q_head.wdata : 8'd0;
        // Read bit phases start at phase one, so the sub-phase pre-wraps.
        sub_next   = (q_head.cmd == sccb_pkg::CMD_READ) ? 2'd2 : 2'd0;
        pins_next  = phase_begin(q_head.cmd, 5'd0, sub_next, shift_next[7], pins);
      end
    end else if (cmd != sccb_pkg::CMD_IDLE) begin
      if (tick_inc >= dur) begin
        tick_next = '0;
        if (cmd == sccb_pkg::CMD_WRITE) begin
          if (phase < 5'd24 && sub == 2'd2) shift_next = {shift[6:0], 1'b0};
          else if (phase == sccb_pkg::WRITE_ACK_PHASE) ack_next = !q_head.sda;
          else if (phase == 5'd27) pins_next.en = 1'b1;
        end else if (cmd == sccb_pkg::CMD_READ) begin
          if (phase != 5'd0 && sub == 2'd1) shift_next = {shift[6:0], q_head.sda};
        end
        sub_next = (sub == 2'd2) ? 2'd0 : sub + 2'd1;
        if (phase_inc >= total) begin
          if (cmd == sccb_pkg::CMD_READ) rdata_next = shift_next;
          cmd_next   = sccb_pkg::CMD_IDLE;
          phase_next = 5'd0;
          done       = 1'b1;
        end else begin
          phase_next = phase_inc;
          pins_next  = phase_begin(cmd, phase_inc, sub_next, shift_next[7], pins_next);
        end
      end else begin
        tick_next = tick_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks    <= sccb_pkg::PHASE_TICKS_RESET;
      ack_wait_ticks <= sccb_pkg::ACK_WAIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        sccb_pkg::CFG_PHASE_TICKS: phase_ticks    <= cfg_data;
        sccb_pkg::CFG_ACK_WAIT:    ack_wait_ticks <= cfg_data;
        default:                   phase_ticks    <= phase_ticks;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd   <= sccb_pkg::CMD_IDLE;
      phase <= 5'd0;
      sub   <= 2'd0;
      tick  <= '0;
      shift <= 8'd0;
      ack   <= 1'b0;
      rdata <= 8'd0;
      pins  <= '{scl: 1'b1, sda: 1'b1, en: 1'b1};
    end else if (pop) begin
      cmd   <= cmd_next;
      phase <= phase_next;
      sub   <= sub_next;
      tick  <= tick_next;
      shift <= shift_next;
      ack   <= ack_next;
      rdata <= rdata_next;
      pins  <= pins_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_tdata <= {1'b0, rej, rdata_next, ack_next, done,
                  (cmd_next != sccb_pkg::CMD_IDLE),
                  pins_next.en, pins_next.sda, pins_next.scl};
    end
  end

endmodule

### rtl/sccb_master_bit_engine_top.sv
// Top level of the SCCB master bit engine: front end, queue and engine.
// Depends on sccb_pkg, sccb_front, sccb_queue and sccb_engine.
//
//  Channel   Dir  Handshake          Payload
//  s_*       in   s_tvalid/s_tready  tuser op; tdata wdata, sda_in
//  m_*       out  m_tvalid/m_tready  tdata scl..rejected, one per request
//  cfg_*     in   cfg_we             cfg_index, cfg_data (16 bit)
//
// One request per clock is sustained while the result register is free or
// being taken; each request is one register update of the phase sequencer in
// the engine. A request is written into the queue when it is accepted and into
// the result register when the engine pops it. Reset is synchronous and
// leaves the bus idle high with SDA driven. A stall on m_tready fills the
// two-entry queue, after which s_tready drops.
`timescale 1ns / 1ps

module sccb_master_bit_engine_top #(
  parameter int TICK_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [15:0]                    cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [sccb_pkg::IN_DATA_W-1:0]  s_tdata,  // wdata[7:0], sda_in[8], zero pad
  input  logic [2:0]                     s_tuser,  // op[2:0]
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // scl[0], sda_out[1], sda_drive[2], busy_res[3], done_res[4], ack_ok[5],
  // rdata[13:6], rejected[14], zero pad
  output logic [sccb_pkg::OUT_DATA_W-1:0] m_tdata
);

  logic            q_full;
  logic            push;
  logic            pop;
  logic            q_not_empty;
  sccb_pkg::item_t front_item;
  sccb_pkg::item_t q_head;

  sccb_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .push     (push),
    .item     (front_item)
  );

  sccb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (front_item),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  sccb_engine #(
    .TICK_WIDTH (TICK_WIDTH)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .pop         (pop),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

endmodule

### rtl/sccb_checker.sv
// Port-level checks for the SCCB master bit engine, bound to the top level.
// Depends on sccb_master_bit_engine_top's port list only.
`timescale 1ns / 1ps

module sccb_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_reject_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[14] |-> m_tdata[3])
    else $error("rejected request while engine idle");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[4] |-> !m_tdata[3] && !m_tdata[14])
    else $error("done pulse while still busy or rejecting");

endmodule

bind sccb_master_bit_engine_top sccb_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

### test/sccb_bus_checker.sv
// Checker for the SCCB master bit engine: predicts the pin and status view
// for every accepted request and compares it with the result stream.
// Depends on sccb_pkg for the command codes and register reset values.
`timescale 1ns / 1ps

module sccb_bus_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [15:0]                     cfg_data,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [sccb_pkg::IN_DATA_W-1:0]  s_tdata,  // wdata[7:0], sda_in[8], zero pad
  input  logic [2:0]                      s_tuser,  // op[2:0]
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  // scl[0], sda_out[1], sda_drive[2], busy_res[3], done_res[4], ack_ok[5],
  // rdata[13:6], rejected[14], zero pad
  input  logic [sccb_pkg::OUT_DATA_W-1:0] m_tdata,
  output int                              fail_count,
  output int                              pending,
  output logic                            bus_busy
);

  typedef struct packed {
    logic       rejected;
    logic [7:0] rdata;
    logic       ack_ok;
    logic       done;
    logic       busy;
    logic       drive;
    logic       sda;
    logic       scl;
  } bus_view_t;

  bus_view_t   expected_views[$];

  sccb_pkg::cmd_t seq_cmd;
  logic [4:0]  seq_phase;
  logic [15:0] tick_cnt;
  logic [7:0]  shreg;
  logic [7:0]  rbyte;
  logic        ack_q;
  logic        scl_q;
  logic        sda_q;
  logic        en_q;
  logic [15:0] phase_len;
  logic [15:0] ack_len;

  // A zero duration behaves as one tick.
  function automatic logic [15:0] hold_len(input sccb_pkg::cmd_t c, input logic [4:0] p);
    logic [15:0] d;
    d = (c == sccb_pkg::CMD_WRITE && p == sccb_pkg::WRITE_ACK_PHASE) ? ack_len : phase_len;
    return (d == 16'd0) ? 16'd1 : d;
  endfunction

  function automatic logic [4:0] phase_count(input sccb_pkg::cmd_t c);
    case (c)
      sccb_pkg::CMD_START: return 5'd4;
      sccb_pkg::CMD_STOP:  return 5'd3;
      sccb_pkg::CMD_WRITE: return 5'd28;
      sccb_pkg::CMD_READ:  return 5'd25;
      sccb_pkg::CMD_NOACK: return 5'd4;
      default:             return 5'd0;
    endcase
  endfunction

  task automatic enter_phase(input sccb_pkg::cmd_t c, input logic [4:0] p);
    case (c)
      sccb_pkg::CMD_START: begin
        if (p == 5'd0) begin
          en_q = 1'b1;
          sda_q = 1'b1;
        end else if (p == 5'd1) scl_q = 1'b1;
        else if (p == 5'd2) sda_q = 1'b0;
        else scl_q = 1'b0;
      end
      sccb_pkg::CMD_STOP: begin
        if (p == 5'd0) begin
          en_q = 1'b1;
          sda_q = 1'b0;
        end else if (p == 5'd1) scl_q = 1'b1;
        else sda_q = 1'b1;
      end
      sccb_pkg::CMD_NOACK: begin
        if (p == 5'd0) begin
          en_q = 1'b1;
          sda_q = 1'b1;
        end else if (p == 5'd1) scl_q = 1'b1;
        else if (p == 5'd2) scl_q = 1'b0;
        else sda_q = 1'b0;
      end
      sccb_pkg::CMD_WRITE: begin
        // Three phases per data bit: set SDA, raise SCL, lower SCL.
        if (p < 5'd24) begin
          if (p % 3 == 0) begin
            en_q = 1'b1;
            sda_q = shreg[7];
          end else if (p % 3 == 1) scl_q = 1'b1;
          else scl_q = 1'b0;
        end else if (p == 5'd25) en_q = 1'b0;
        else if (p == 5'd26) scl_q = 1'b1;
        else if (p == 5'd27) scl_q = 1'b0;
      end
      sccb_pkg::CMD_READ: begin
        if (p == 5'd0) en_q = 1'b0;
        else if ((p - 5'd1) % 3 == 1) scl_q = 1'b1;
        else if ((p - 5'd1) % 3 == 2) scl_q = 1'b0;
      end
      default: ;
    endcase
  endtask

  task automatic leave_phase(input sccb_pkg::cmd_t c, input logic [4:0] p,
                             input logic sda_pin);
    if (c == sccb_pkg::CMD_WRITE) begin
      if (p < 5'd24 && p % 3 == 2) shreg = {shreg[6:0], 1'b0};
      else if (p == sccb_pkg::WRITE_ACK_PHASE) ack_q = !sda_pin;
      else if (p == 5'd27) en_q = 1'b1;
    end else if (c == sccb_pkg::CMD_READ) begin
      if (p >= 5'd1 && (p - 5'd1) % 3 == 1) shreg = {shreg[6:0], sda_pin};
    end
  endtask

  task automatic advance_engine(input logic [2:0] op, input logic [7:0] wd,
                                input logic sda_pin, output bus_view_t v);
    v = '0;
    if (op >= sccb_pkg::CMD_START && op <= sccb_pkg::CMD_NOACK) begin
      if (seq_cmd != sccb_pkg::CMD_IDLE) begin
        v.rejected = 1'b1;
      end else begin
        seq_cmd = sccb_pkg::cmd_t'(op);
        seq_phase = 5'd0;
        tick_cnt = 16'd0;
        shreg = (op == sccb_pkg::CMD_WRITE) ? wd : 8'h00;
        enter_phase(seq_cmd, 5'd0);
      end
    end else if (seq_cmd != sccb_pkg::CMD_IDLE) begin
      // Ticks and the two unused op codes advance time alike.
      tick_cnt = tick_cnt + 16'd1;
      if (tick_cnt >= hold_len(seq_cmd, seq_phase)) begin
        leave_phase(seq_cmd, seq_phase, sda_pin);
        tick_cnt = 16'd0;
        seq_phase = seq_phase + 5'd1;
        if (seq_phase >= phase_count(seq_cmd)) begin
          if (seq_cmd == sccb_pkg::CMD_READ) rbyte = shreg;
          seq_cmd = sccb_pkg::CMD_IDLE;
          seq_phase = 5'd0;
          v.done = 1'b1;
        end else begin
          enter_phase(seq_cmd, seq_phase);
        end
      end
    end
    v.scl = scl_q;
    v.sda = sda_q;
    v.drive = en_q;
    v.busy = (seq_cmd != sccb_pkg::CMD_IDLE);
    v.ack_ok = ack_q;
    v.rdata = rbyte;
  endtask

  always @(posedge clk) begin : watch
    bus_view_t got;
    bus_view_t want;
    if (rst) begin
      expected_views.delete();
      fail_count = 0;
      seq_cmd = sccb_pkg::CMD_IDLE;
      seq_phase = 5'd0;
      tick_cnt = 16'd0;
      shreg = 8'h00;
      rbyte = 8'h00;
      ack_q = 1'b0;
      scl_q = 1'b1;
      sda_q = 1'b1;
      en_q = 1'b1;
      phase_len = sccb_pkg::PHASE_TICKS_RESET;
      ack_len = sccb_pkg::ACK_WAIT_RESET;
    end else begin
      if (cfg_we) begin
        if (cfg_index == sccb_pkg::CFG_PHASE_TICKS) phase_len = cfg_data;
        else ack_len = cfg_data;
      end
      if (m_tvalid && m_tready) begin
        got = bus_view_t'(m_tdata[14:0]);
        if (expected_views.size() == 0) begin
          if (fail_count < 10) $display("%t: result %h arrived with nothing pending",
                                        $realtime, m_tdata);
          fail_count++;
        end else begin
          want = expected_views.pop_front();
          if (got.scl !== want.scl || got.sda !== want.sda || got.drive !== want.drive ||
              got.busy !== want.busy || got.done !== want.done ||
              got.ack_ok !== want.ack_ok || got.rdata !== want.rdata ||
              got.rejected !== want.rejected) begin
            if (fail_count < 10) begin
              $display("%t: mismatch scl/sda/drive/busy/done/ack/rdata/rej", $realtime);
              $display("  expected %b %b %b %b %b %b %h %b", want.scl, want.sda,
                       want.drive, want.busy, want.done, want.ack_ok, want.rdata,
                       want.rejected);
              $display("  actual   %b %b %b %b %b %b %h %b", got.scl, got.sda,
                       got.drive, got.busy, got.done, got.ack_ok, got.rdata,
                       got.rejected);
            end
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        advance_engine(s_tuser, s_tdata[7:0], s_tdata[8], want);
        expected_views.push_back(want);
      end
    end
    pending <= expected_views.size();
    bus_busy <= (seq_cmd != sccb_pkg::CMD_IDLE);
  end

endmodule

### test/sccb_master_bit_engine_top_tb.sv
// Stimulus and verdict for the SCCB master bit engine top level.
// Depends on sccb_pkg, the engine RTL and the sccb_bus_checker module.
`timescale 1ns / 1ps

module sccb_master_bit_engine_top_tb;

  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;
  localparam int         LIMIT    = 100000;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_we = 1'b0;
  logic                            cfg_index = 1'b0;
  logic [15:0]                     cfg_data = '0;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [sccb_pkg::IN_DATA_W-1:0]  s_tdata = '0;   // wdata[7:0], sda_in[8], zero pad
  logic [2:0]                      s_tuser = '0;   // op[2:0]
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  // scl[0], sda_out[1], sda_drive[2], busy_res[3], done_res[4], ack_ok[5],
  // rdata[13:6], rejected[14], zero pad
  logic [sccb_pkg::OUT_DATA_W-1:0] m_tdata;

  int   fail_count;
  int   pending;
  logic bus_busy;

  int   cycles = 0;
  int   burst_left = 0;
  bit   no_gaps = 1'b0;
  int   pt_now = int'(sccb_pkg::PHASE_TICKS_RESET);
  int   aw_now = int'(sccb_pkg::ACK_WAIT_RESET);
  int   hold_token = 0;
  int   hold_seen = 0;
  int   long_hold = 0;
  int   rx_left = 0;
  bit   rx_on = 1'b0;

  sccb_master_bit_engine_top uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  sccb_bus_checker u_bus_check (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .fail_count(fail_count), .pending(pending), .bus_busy(bus_busy)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: alternating ready and stall stretches, plus a long
  // hold-off whenever the stimulus bumps the hold token.
  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      long_hold = 300;
    end
    if (long_hold > 0) begin
      long_hold--;
      m_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_on = !rx_on;
        rx_left = rx_on ? $urandom_range(1, 40) : $urandom_range(1, 5);
      end
      rx_left--;
      m_tready <= rx_on;
    end
  end

  initial begin
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("sccb_master_bit_engine_top_tb NOT OK");
    $finish;
  end

  // Offers one request and returns at the edge where it is taken.
  task automatic send_item(input logic [2:0] op, input logic [7:0] wd, input logic sd);
    int gap;
    if (!no_gaps && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {{(sccb_pkg::IN_DATA_W - 9){1'b0}}, sd, wd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  function automatic logic [2:0] tick_op();
    int r;
    r = $urandom_range(0, 9);
    if (r == 8) return OP_RSVD6;
    if (r == 9) return OP_RSVD7;
    return OP_TICK;
  endfunction

  // SDA mode: 0 held low, 1 held high, otherwise random.
  task automatic send_ticks(input int n, input int mode);
    for (int i = 0; i < n; i++)
      send_item(tick_op(), 8'($urandom),
                (mode > 1) ? 1'($urandom_range(0, 1)) : 1'(mode));
  endtask

  // Ticks a command needs under the current durations.
  function automatic int seq_ticks(input logic [2:0] op);
    int p;
    int a;
    p = (pt_now == 0) ? 1 : pt_now;
    a = (aw_now == 0) ? 1 : aw_now;
    case (op)
      sccb_pkg::CMD_START, sccb_pkg::CMD_NOACK: return 4 * p;
      sccb_pkg::CMD_STOP:                       return 3 * p;
      sccb_pkg::CMD_WRITE:                      return 27 * p + a;
      sccb_pkg::CMD_READ:                       return 25 * p;
      default:                                  return 0;
    endcase
  endfunction

  task automatic wait_quiet();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Lets any command still on the bus run out before the next phase.
  task automatic finish_bus();
    wait_quiet();
    while (bus_busy) begin
      send_ticks(16, 2);
      wait_quiet();
    end
  endtask

  task automatic write_cfg(input logic idx, input int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[15:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == sccb_pkg::CFG_PHASE_TICKS) pt_now = value;
    else aw_now = value;
  endtask

  task automatic run_random(input int budget);
    int sent;
    int len;
    int k;
    int cut;
    logic [2:0] c;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 99) < 75) begin
        c = 3'($urandom_range(1, 5));
        send_item(c, 8'($urandom), 1'($urandom_range(0, 1)));
        len = seq_ticks(c);
        k = $urandom_range(0, 99);
        // Cut runs leave the next command landing on a busy engine.
        if (k < 15) len = $urandom_range(0, len);
        else if (k >= 90) len += $urandom_range(1, 4);
        cut = (k >= 15 && k < 25) ? $urandom_range(0, len) : -1;
        for (int i = 0; i < len; i++) begin
          if (i == cut) begin
            send_item(3'($urandom_range(1, 5)), 8'($urandom), 1'($urandom_range(0, 1)));
            sent++;
          end
          send_item(tick_op(), 8'($urandom), 1'($urandom_range(0, 1)));
        end
        sent += len + 1;
      end else begin
        len = $urandom_range(1, 6);
        repeat (len)
          send_item(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom_range(0, 1)));
        sent += len;
      end
    end
  endtask

  initial begin : stimulus
    int pt_set[6];
    int aw_set[6];
    pt_set = '{1, 2, 1, 3, 0, 2};
    aw_set = '{1, 1, 5, 2, 0, 3};

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset durations, with idle ticks of every tick-like op first. Each long
    // hold is entered, then cut short by a smaller duration once quiet.
    send_item(OP_TICK, 8'hFF, 1'b1);
    send_item(OP_RSVD6, 8'h00, 1'b0);
    send_item(OP_RSVD7, 8'hFF, 1'b1);
    send_item(sccb_pkg::CMD_START, 8'h00, 1'b0);
    send_ticks(150, 2);
    wait_quiet();
    write_cfg(sccb_pkg::CFG_PHASE_TICKS, 1);
    finish_bus();
    send_item(sccb_pkg::CMD_WRITE, 8'h5A, 1'b0);
    send_ticks(67, 2);
    wait_quiet();
    write_cfg(sccb_pkg::CFG_ACK_WAIT, 1);
    finish_bus();

    write_cfg(sccb_pkg::CFG_PHASE_TICKS, 1);
    write_cfg(sccb_pkg::CFG_ACK_WAIT, 1);

    // Commands while busy are refused and do not advance time.
    send_item(sccb_pkg::CMD_START, 8'h00, 1'b0);
    send_ticks(1, 2);
    send_item(sccb_pkg::CMD_WRITE, 8'hFF, 1'b1);
    send_item(sccb_pkg::CMD_READ, 8'h00, 1'b0);
    send_ticks(3, 2);
    send_item(sccb_pkg::CMD_WRITE, 8'hFF, 1'b1);
    send_item(OP_RSVD6, 8'h00, 1'b0);
    send_item(OP_RSVD7, 8'h00, 1'b0);
    send_ticks(26, 0);
    send_item(sccb_pkg::CMD_WRITE, 8'h00, 1'b0);
    send_ticks(28, 1);
    send_item(sccb_pkg::CMD_READ, 8'h00, 1'b0);
    send_ticks(25, 1);
    send_item(sccb_pkg::CMD_READ, 8'hFF, 1'b1);
    send_ticks(25, 0);
    send_item(sccb_pkg::CMD_NOACK, 8'h00, 1'b0);
    send_item(sccb_pkg::CMD_STOP, 8'h00, 1'b0);
    send_ticks(4, 2);
    send_item(sccb_pkg::CMD_STOP, 8'h00, 1'b0);
    send_ticks(3, 2);
    finish_bus();

    for (int ph = 0; ph < 6; ph++) begin
      write_cfg(sccb_pkg::CFG_PHASE_TICKS, pt_set[ph]);
      write_cfg(sccb_pkg::CFG_ACK_WAIT, aw_set[ph]);
      no_gaps = (ph == 3);
      if (ph == 1) hold_token <= hold_token + 1;
      run_random(170);
      finish_bus();
    end

    // Longest durations, sent back to back: each hold is entered, then cut
    // short by a smaller duration once quiet.
    no_gaps = 1'b1;
    write_cfg(sccb_pkg::CFG_PHASE_TICKS, 65535);
    send_item(sccb_pkg::CMD_STOP, 8'h00, 1'b0);
    send_ticks(100, 2);
    wait_quiet();
    write_cfg(sccb_pkg::CFG_PHASE_TICKS, 1);
    finish_bus();
    write_cfg(sccb_pkg::CFG_ACK_WAIT, 65535);
    send_item(sccb_pkg::CMD_WRITE, 8'($urandom), 1'b0);
    send_ticks(60, 2);
    wait_quiet();
    write_cfg(sccb_pkg::CFG_ACK_WAIT, 1);
    finish_bus();
    no_gaps = 1'b0;

    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("sccb_master_bit_engine_top_tb OK");
    end else begin
      $display("sccb_master_bit_engine_top_tb NOT OK");
    end
    $finish;
  end

endmodule
